// ===== rtl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Types and constants shared by the DER sibling element scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  // Record kinds
  localparam logic REC_HEADER = 1'b0;
  localparam logic REC_END    = 1'b1;

  // End record status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADFORM = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  // DER length byte fields
  localparam logic [7:0] LEN_LONG_BIT = 8'h80;
  localparam logic [6:0] LEN_N_MASK   = 7'h7F;

  // Scan phase, one-hot
  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_LONG    = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_DEAD    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  element_tag;
    logic [31:0] content_offset;
    logic [31:0] content_length;
    logic [1:0]  status;
    logic        run_last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/der_tlv_sibling_scanner_top.sv =====
// ----------------------------------------------------------------------------
// der_tlv_sibling_scanner_top
// Scans a region of sibling DER elements and reports headers and region end.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_data  (in_item_t)
//   out_      output     out_valid/ out_stall out_data (out_item_t)
//   cfg_      input      cfg_valid/ cfg_ready cfg_data (base_offset, 32 bits)
//
// One byte per cycle while the input is not stalled. A byte waits in the input
// register, where the scan state is updated and its 0..2 records are pushed
// into a 4-entry result queue; from the queue the records are shown on out_.
// The input stalls only while the queue holds more than two records.
// rst_n is synchronous: it clears the scan state, the queue and base_offset.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module der_tlv_sibling_scanner_top
  import dts_pkg::*;
#(
  parameter int MAX_LEN_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,

  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int QD = 4;
  localparam int QW = $clog2(QD);

  // configuration
  logic [31:0] base_r;

  // input register
  logic     in_vld_r;
  in_item_t in_item_r;

  // scan state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  lbl_r, lbl_nxt;
  logic [31:0] cleft_r, cleft_nxt;
  logic [31:0] pos_r, pos_nxt;

  // result queue
  out_item_t   q_r [QD];
  logic [QW-1:0] q_head_r, q_tail_r;
  logic [QW:0]   q_cnt_r, q_cnt_nxt;

  logic        room;
  logic        advance;
  logic        in_acc;
  logic        pop;

  logic        hdr_vld;
  logic [31:0] hdr_len;
  logic        end_vld;
  logic [1:0]  end_st;
  phase_t      ph_step;
  logic [6:0]  len_n;
  logic [31:0] cl_dec;
  logic [31:0] acc_step;
  out_item_t   rec0, rec1;
  logic [1:0]  push_n;

  assign cfg_ready = 1'b1;

  assign room     = (q_cnt_r <= (QW+1)'(QD - 2));
  assign advance  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_r[q_head_r];

  assign len_n  = in_item_r.data_byte[6:0] & LEN_N_MASK;
  assign cl_dec = (cleft_r != '0) ? cleft_r - 32'd1 : cleft_r;
  // saturate once another byte would shift bits out of 32
  assign acc_step = (accum_r > 32'h00FF_FFFF) ? 32'hFFFF_FFFF
                                              : {accum_r[23:0], in_item_r.data_byte};

  // one byte of scan
  always_comb begin
    ph_step   = phase_r;
    tag_nxt   = tag_r;
    accum_nxt = accum_r;
    lbl_nxt   = lbl_r;
    cleft_nxt = cleft_r;
    pos_nxt   = pos_r;
    hdr_vld   = 1'b0;
    hdr_len   = '0;
    end_vld   = 1'b0;
    end_st    = ST_OK;

    unique case (phase_r)
      PH_TAG: begin
        tag_nxt = in_item_r.data_byte;
        ph_step = PH_LEN;
      end
      PH_LEN: begin
        if ((in_item_r.data_byte & LEN_LONG_BIT) == '0) begin
          hdr_vld = 1'b1;
          hdr_len = {24'd0, in_item_r.data_byte};
        end else if (len_n == '0 || 32'(len_n) > 32'(MAX_LEN_BYTES)) begin
          ph_step = PH_DEAD;
        end else begin
          accum_nxt = '0;
          lbl_nxt   = 3'(len_n - 7'd1);
          ph_step   = PH_LONG;
        end
      end
      PH_LONG: begin
        accum_nxt = acc_step;
        if (lbl_r == '0) begin
          hdr_vld = 1'b1;
          hdr_len = acc_step;
        end else begin
          lbl_nxt = lbl_r - 3'd1;
        end
      end
      PH_CONTENT: begin
        cleft_nxt = cl_dec;
        if (cl_dec == '0) ph_step = PH_TAG;
      end
      default: begin
        ph_step = PH_DEAD;
      end
    endcase

    if (hdr_vld) begin
      cleft_nxt = hdr_len;
      ph_step   = (hdr_len == '0) ? PH_TAG : PH_CONTENT;
    end

    phase_nxt = ph_step;
    if (in_item_r.last_byte) begin
      end_vld = 1'b1;
      priority if (ph_step == PH_DEAD) end_st = ST_BADFORM;
      else if (ph_step == PH_TAG)      end_st = ST_OK;
      else                             end_st = ST_TRUNC;
      phase_nxt = PH_TAG;
      tag_nxt   = '0;
      accum_nxt = '0;
      lbl_nxt   = '0;
      cleft_nxt = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = pos_r + 32'd1;
    end
  end

  // build records; the first slot takes whichever comes first
  always_comb begin
    out_item_t hdr_rec, end_rec;
    hdr_rec.record_kind    = REC_HEADER;
    hdr_rec.element_tag    = tag_r;
    hdr_rec.content_offset = base_r + pos_r + 32'd1;
    hdr_rec.content_length = hdr_len;
    hdr_rec.status         = ST_OK;
    hdr_rec.run_last       = !end_vld;

    end_rec.record_kind    = REC_END;
    end_rec.element_tag    = '0;
    end_rec.content_offset = '0;
    end_rec.content_length = '0;
    end_rec.status         = end_st;
    end_rec.run_last       = 1'b1;

    rec0   = hdr_vld ? hdr_rec : end_rec;
    rec1   = end_rec;
    push_n = advance ? (2'(hdr_vld) + 2'(end_vld)) : 2'd0;
  end

  assign q_cnt_nxt = q_cnt_r + (QW+1)'(push_n) - (QW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      in_vld_r <= 1'b0;
      phase_r  <= PH_TAG;
      tag_r    <= '0;
      accum_r  <= '0;
      lbl_r    <= '0;
      cleft_r  <= '0;
      pos_r    <= '0;
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) base_r <= cfg_data;

      if (in_acc)       in_vld_r <= 1'b1;
      else if (advance) in_vld_r <= 1'b0;

      if (advance) begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        accum_r <= accum_nxt;
        lbl_r   <= lbl_nxt;
        cleft_r <= cleft_nxt;
        pos_r   <= pos_nxt;
      end

      if (pop) q_head_r <= q_head_r + QW'(1);
      q_tail_r <= q_tail_r + QW'(push_n);
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) in_item_r <= in_data;
    if (push_n != 2'd0) q_r[q_tail_r] <= rec0;
    if (push_n == 2'd2) q_r[q_tail_r + QW'(1)] <= rec1;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QW+1)'(QD))
    else $error("result queue overflow");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.last_byte |=> phase_r == PH_TAG && pos_r == '0)
    else $error("scan not restarted after last byte");

  a_hdr_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == REC_HEADER |->
      out_data.status == ST_OK && out_data.run_last == 1'b0 ||
      out_data.status == ST_OK && out_data.run_last == 1'b1)
    else $error("header record with nonzero status");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_cnt_r > (QW+1)'(QD - 2))
    else $error("input stalled with queue room");

endmodule

`default_nettype wire
